[src/epg_pkg.sv]
// epg_pkg: shared types, constants and control store for the epicycle point generator
// no dependencies; imported by epg_mac, epg_seq and epicycle_point_generator_top
package epg_pkg;

   localparam int NUM_ARMS      = 3;
   localparam int ARM_IDX_W     = 2;
   localparam int FRAC_BITS_DEF = 15;

   localparam int VEC_W    = 16;
   localparam int ROT_W    = 32;
   localparam int PROD_W   = 2 * VEC_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int JOINT2_W = VEC_W + 1;
   localparam int HEAD_W   = VEC_W + 2;

   localparam logic [ARM_IDX_W-1:0] FIRST_ARM = '0;
   localparam logic [ARM_IDX_W-1:0] LAST_ARM  = ARM_IDX_W'(NUM_ARMS - 1);

   // register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM0_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM1_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM2_LENGTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM0_ROTATION = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM1_ROTATION = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM2_ROTATION = 3'd5;

   localparam logic signed [VEC_W-1:0] ARM0_LENGTH_RST = 16'sd6554;
   localparam logic signed [VEC_W-1:0] ARM1_LENGTH_RST = 16'sd3277;
   localparam logic signed [VEC_W-1:0] ARM2_LENGTH_RST = 16'sd3277;
   localparam logic [ROT_W-1:0] ARM0_ROTATION_RST = 32'd2147025551;
   localparam logic [ROT_W-1:0] ARM1_ROTATION_RST = 32'd2147352904;
   localparam logic [ROT_W-1:0] ARM2_ROTATION_RST = 32'd2146237317;

   typedef enum logic [1:0] {
      MUL_CX,
      MUL_SY,
      MUL_SX,
      MUL_CY
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_WAIT_REQ,
      BR_ARM_LOOP,
      BR_WAIT_RSP
   } branch_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        latch_x;
      logic        write_arm;
      branch_type  branch;
   } uword_type;

   typedef struct packed {
      logic                 ready;
      logic                 accept;
      logic                 finish;
      mul_sel_type          mul_sel;
      acc_op_type           acc_op;
      logic                 latch_x;
      logic                 write_arm;
      logic [ARM_IDX_W-1:0] arm_i;
      logic [ARM_IDX_W-1:0] arm_j;
   } ctrl_type;

   localparam int UPC_W = 3;
   localparam logic [UPC_W-1:0] UPC_IDLE = 3'd0;
   localparam logic [UPC_W-1:0] UPC_ROT  = 3'd1;
   localparam logic [UPC_W-1:0] UPC_DONE = 3'd7;

   // control store: one rotation of arm j by the angle of arm i takes steps 1..6
   function automatic uword_type ucode_word(input logic [UPC_W-1:0] upc);
      uword_type w;
      w = '{mul_sel: MUL_CX, acc_op: ACC_HOLD, latch_x: 1'b0, write_arm: 1'b0,
            branch: BR_NEXT};
      case (upc)
         3'd0: w.branch = BR_WAIT_REQ;
         3'd1: w.mul_sel = MUL_CX;
         3'd2: begin
            w.mul_sel = MUL_SY;
            w.acc_op  = ACC_LOAD;
         end
         3'd3: begin
            w.mul_sel = MUL_SX;
            w.acc_op  = ACC_SUB;
         end
         3'd4: begin
            w.mul_sel = MUL_CY;
            w.acc_op  = ACC_LOAD;
            w.latch_x = 1'b1;
         end
         3'd5: w.acc_op = ACC_ADD;
         3'd6: begin
            w.write_arm = 1'b1;
            w.branch    = BR_ARM_LOOP;
         end
         3'd7: w.branch = BR_WAIT_RSP;
         default: w.branch = BR_WAIT_REQ;
      endcase
      return w;
   endfunction

endpackage

[src/epg_mac.sv]
// epg_mac: shared 16x16 multiplier, accumulator and round/saturate for arm rotation
// depends on epg_pkg
module epg_mac
   import epg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  ctrl_type                ctrl,
   input  logic signed [VEC_W-1:0] rot_cos,
   input  logic signed [VEC_W-1:0] rot_sin,
   input  logic signed [VEC_W-1:0] vec_x,
   input  logic signed [VEC_W-1:0] vec_y,
   output logic signed [VEC_W-1:0] new_x,
   output logic signed [VEC_W-1:0] new_y
);

   localparam int SUM_W = ACC_W + 1;
   localparam logic signed [SUM_W-1:0] RND_HALF =
      {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-VEC_W+1){1'b1}}, {(VEC_W-1){1'b0}}};

   logic signed [VEC_W-1:0]  mul_a;
   logic signed [VEC_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [VEC_W-1:0]  xnew_ff;

   // round to nearest (ties up), floor shift, clamp to 16 bits
   function automatic logic signed [VEC_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] shifted;
      logic signed [VEC_W-1:0] r;
      sum     = {a[ACC_W-1], a} + RND_HALF;
      shifted = sum >>> FRAC_BITS;
      if (shifted > SAT_HI) begin
         r = SAT_HI[VEC_W-1:0];
      end else if (shifted < SAT_LO) begin
         r = SAT_LO[VEC_W-1:0];
      end else begin
         r = shifted[VEC_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      mul_a = (ctrl.mul_sel == MUL_CX || ctrl.mul_sel == MUL_CY) ? rot_cos : rot_sin;
      mul_b = (ctrl.mul_sel == MUL_CX || ctrl.mul_sel == MUL_SX) ? vec_x : vec_y;
   end

   assign prod_ext = {prod_ff[PROD_W-1], prod_ff};

   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      if (ctrl.latch_x) begin
         xnew_ff <= round_sat(acc_ff);
      end
   end

   assign new_x = xnew_ff;
   assign new_y = round_sat(acc_ff);

endmodule

[src/epg_seq.sv]
// epg_seq: step counter, arm loop counters and branch logic over the control store
// depends on epg_pkg
module epg_seq
   import epg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     rsp_free,
   output ctrl_type ctrl
);

   logic [UPC_W-1:0]     upc_ff;
   logic [UPC_W-1:0]     upc_in;
   logic [ARM_IDX_W-1:0] arm_i_ff;
   logic [ARM_IDX_W-1:0] arm_i_in;
   logic [ARM_IDX_W-1:0] arm_j_ff;
   logic [ARM_IDX_W-1:0] arm_j_in;
   uword_type            uw;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff   <= UPC_IDLE;
         arm_i_ff <= LAST_ARM;
         arm_j_ff <= LAST_ARM;
      end else begin
         upc_ff   <= upc_in;
         arm_i_ff <= arm_i_in;
         arm_j_ff <= arm_j_in;
      end
   end

   always_comb begin
      uw       = ucode_word(upc_ff);
      upc_in   = upc_ff + UPC_W'(1);
      arm_i_in = arm_i_ff;
      arm_j_in = arm_j_ff;

      ctrl.ready     = 1'b0;
      ctrl.accept    = 1'b0;
      ctrl.finish    = 1'b0;
      ctrl.mul_sel   = uw.mul_sel;
      ctrl.acc_op    = uw.acc_op;
      ctrl.latch_x   = uw.latch_x;
      ctrl.write_arm = uw.write_arm;
      ctrl.arm_i     = arm_i_ff;
      ctrl.arm_j     = arm_j_ff;

      case (uw.branch)
         BR_WAIT_REQ: begin
            ctrl.ready = 1'b1;
            if (req_valid) begin
               ctrl.accept = 1'b1;
               upc_in      = UPC_ROT;
               arm_i_in    = LAST_ARM;
               arm_j_in    = LAST_ARM;
            end else begin
               upc_in = upc_ff;
            end
         end
         BR_ARM_LOOP: begin
            // outer arms first; each arm's angle also turns every arm beyond it
            upc_in = UPC_ROT;
            if (arm_j_ff != LAST_ARM) begin
               arm_j_in = arm_j_ff + ARM_IDX_W'(1);
            end else if (arm_i_ff == FIRST_ARM) begin
               upc_in = UPC_DONE;
            end else begin
               arm_i_in = arm_i_ff - ARM_IDX_W'(1);
               arm_j_in = arm_i_ff - ARM_IDX_W'(1);
            end
         end
         BR_WAIT_RSP: begin
            if (rsp_free) begin
               ctrl.finish = 1'b1;
               upc_in      = UPC_IDLE;
            end else begin
               upc_in = upc_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

[src/epicycle_point_generator_top.sv]
// epicycle_point_generator_top: config registers, arm vector registers and result register
// depends on epg_pkg, epg_seq, epg_mac
//
//   port group   dir    handshake              payload
//   req_         in     req_valid/req_ready    req_restart
//   rsp_         out    rsp_valid/rsp_ready    joint1, joint2, head (x, y)
//   csr_         in     csr_valid/csr_ready    csr_index, csr_wdata
//
// a request is accepted in the idle step; its result is registered at the finish
// step, after six arm rotations of six steps each on the one shared multiplier.
// the idle step follows, so a new request is taken only once the last is done.
// a result held by rsp_ready low stalls the sequencer only at its finish step.
// reset restores the register defaults and reloads the arms; csr writes take
// effect at once, lengths reach the arms only on a restart.
module epicycle_point_generator_top
   import epg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VEC_W-1:0]    rsp_joint1_x,
   output logic signed [VEC_W-1:0]    rsp_joint1_y,
   output logic signed [JOINT2_W-1:0] rsp_joint2_x,
   output logic signed [JOINT2_W-1:0] rsp_joint2_y,
   output logic signed [HEAD_W-1:0]   rsp_head_x,
   output logic signed [HEAD_W-1:0]   rsp_head_y,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [ROT_W-1:0]           csr_wdata
);

   ctrl_type ctrl;

   logic signed [VEC_W-1:0] arm_len_ff [NUM_ARMS];
   logic [ROT_W-1:0]        arm_rot_ff [NUM_ARMS];
   logic signed [VEC_W-1:0] arm_x_ff   [NUM_ARMS];
   logic signed [VEC_W-1:0] arm_y_ff   [NUM_ARMS];

   logic signed [VEC_W-1:0] new_x;
   logic signed [VEC_W-1:0] new_y;
   logic                    rsp_free;

   logic                       rsp_valid_ff;
   logic signed [VEC_W-1:0]    joint1_x_ff;
   logic signed [VEC_W-1:0]    joint1_y_ff;
   logic signed [JOINT2_W-1:0] joint2_x_ff;
   logic signed [JOINT2_W-1:0] joint2_y_ff;
   logic signed [HEAD_W-1:0]   head_x_ff;
   logic signed [HEAD_W-1:0]   head_y_ff;
   logic signed [JOINT2_W-1:0] joint2_x_in;
   logic signed [JOINT2_W-1:0] joint2_y_in;
   logic signed [HEAD_W-1:0]   head_x_in;
   logic signed [HEAD_W-1:0]   head_y_in;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctrl.ready;

   epg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl)
   );

   epg_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .ctrl    (ctrl),
      .rot_cos (arm_rot_ff[ctrl.arm_i][ROT_W-1:VEC_W]),
      .rot_sin (arm_rot_ff[ctrl.arm_i][VEC_W-1:0]),
      .vec_x   (arm_x_ff[ctrl.arm_j]),
      .vec_y   (arm_y_ff[ctrl.arm_j]),
      .new_x   (new_x),
      .new_y   (new_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_len_ff[0] <= ARM0_LENGTH_RST;
         arm_len_ff[1] <= ARM1_LENGTH_RST;
         arm_len_ff[2] <= ARM2_LENGTH_RST;
         arm_rot_ff[0] <= ARM0_ROTATION_RST;
         arm_rot_ff[1] <= ARM1_ROTATION_RST;
         arm_rot_ff[2] <= ARM2_ROTATION_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ARM0_LENGTH:   arm_len_ff[0] <= csr_wdata[VEC_W-1:0];
            CSR_ARM1_LENGTH:   arm_len_ff[1] <= csr_wdata[VEC_W-1:0];
            CSR_ARM2_LENGTH:   arm_len_ff[2] <= csr_wdata[VEC_W-1:0];
            CSR_ARM0_ROTATION: arm_rot_ff[0] <= csr_wdata;
            CSR_ARM1_ROTATION: arm_rot_ff[1] <= csr_wdata;
            CSR_ARM2_ROTATION: arm_rot_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_x_ff[0] <= ARM0_LENGTH_RST;
         arm_x_ff[1] <= ARM1_LENGTH_RST;
         arm_x_ff[2] <= ARM2_LENGTH_RST;
         for (int k = 0; k < NUM_ARMS; k++) begin
            arm_y_ff[k] <= '0;
         end
      end else if (ctrl.accept && req_restart) begin
         for (int k = 0; k < NUM_ARMS; k++) begin
            arm_x_ff[k] <= arm_len_ff[k];
            arm_y_ff[k] <= '0;
         end
      end else if (ctrl.write_arm) begin
         arm_x_ff[ctrl.arm_j] <= new_x;
         arm_y_ff[ctrl.arm_j] <= new_y;
      end
   end

   // joint sums grow one bit per arm and cannot overflow
   always_comb begin
      joint2_x_in = JOINT2_W'(arm_x_ff[0]) + JOINT2_W'(arm_x_ff[1]);
      joint2_y_in = JOINT2_W'(arm_y_ff[0]) + JOINT2_W'(arm_y_ff[1]);
      head_x_in   = HEAD_W'(joint2_x_in) + HEAD_W'(arm_x_ff[2]);
      head_y_in   = HEAD_W'(joint2_y_in) + HEAD_W'(arm_y_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         joint1_x_ff <= arm_x_ff[0];
         joint1_y_ff <= arm_y_ff[0];
         joint2_x_ff <= joint2_x_in;
         joint2_y_ff <= joint2_y_in;
         head_x_ff   <= head_x_in;
         head_y_ff   <= head_y_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_joint1_x = joint1_x_ff;
   assign rsp_joint1_y = joint1_y_ff;
   assign rsp_joint2_x = joint2_x_ff;
   assign rsp_joint2_y = joint2_y_ff;
   assign rsp_head_x   = head_x_ff;
   assign rsp_head_y   = head_y_ff;

endmodule
